// ===== hw/rtl/nec_pkg.sv =====
// Shared constants and register indexes for the NLMS echo canceller.
`timescale 1ns / 1ps
package nec_pkg;

  localparam int unsigned MAX_TAPS_DEF = 1024;
  localparam int unsigned MIN_TAPS     = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CANCEL_EN  = 3'd4;

  localparam logic [10:0] TAP_COUNT_RST = 11'd128;
  localparam logic [15:0] STEP_SIZE_RST = 16'd328;
  localparam logic [16:0] LEAK_RST      = 17'd65470;
  localparam logic [15:0] REF_GAIN_RST  = 16'd4096;
  localparam logic        CANCEL_EN_RST = 1'b1;

  // Input opcodes
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Sample and history widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned HIST_W   = 20;
  localparam int unsigned WEIGHT_W = 32;

  // Update numerator: (mu * |e| * |x|) << 12 plus half the divisor
  localparam int unsigned NUM_W = 63;

endpackage

// ===== hw/rtl/nec_if.sv =====
// Valid/ready channel interfaces for samples, results and configuration.
`timescale 1ns / 1ps
interface nec_in_if;
  import nec_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic signed [SAMPLE_W-1:0] mic_sample;
  logic signed [SAMPLE_W-1:0] ref_sample;
  logic                       block_end;
  modport source (output valid, opcode, mic_sample, ref_sample, block_end, input ready);
  modport sink   (input valid, opcode, mic_sample, ref_sample, block_end, output ready);
endinterface

interface nec_out_if;
  import nec_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] clean_sample;
  logic                       block_end_out;
  logic                       clipped;
  modport source (output valid, clean_sample, block_end_out, clipped, input ready);
  modport sink   (input valid, clean_sample, block_end_out, clipped, output ready);
endinterface

interface nec_cfg_if;
  import nec_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/nlms_echo_canceller_unit.sv =====
// Top level of the leaky NLMS echo canceller: sequencer, tap memories, datapath.
//
// One sample pair is processed at a time; the input is not ready while an item is
// in work. With N taps in use, a processed item makes a filter pass (history
// shift, echo estimate and reference power share one walk over both memories)
// and then a weight update, where each tap waits on the 63-step iterative divider
// that normalizes the gradient; the divider sets the rate. A bypass item goes
// straight to the done state. A clear item, and reset, run a clearing pass over all
// MAX_TAPS entries of both memories before the next item is taken. The result waits
// in an output register, so the block finishes the next item's work while the
// previous result is held.
`timescale 1ns / 1ps
module nlms_echo_canceller_unit #(
  parameter int unsigned MAX_TAPS = nec_pkg::MAX_TAPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nec_cfg_if.sink   cfg_i,
  nec_in_if.sink    in_i,
  nec_out_if.source out_o
);
  import nec_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_TAPS);
  localparam int unsigned ACC_W = 52 + AW;
  localparam int unsigned PW    = 39 + AW;
  localparam int unsigned ERR_W = ACC_W - 26;

  localparam logic signed [ACC_W:0] EST_HALF = (ACC_W + 1)'(1) <<< 27;

  // Sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MRD  = 4'd2;
  localparam logic [3:0] S_MAC  = 4'd3;
  localparam logic [3:0] S_MACC = 4'd4;
  localparam logic [3:0] S_EST  = 4'd5;
  localparam logic [3:0] S_EX   = 4'd6;
  localparam logic [3:0] S_URD  = 4'd7;
  localparam logic [3:0] S_UMUL = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_WUP  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic [10:0] tap_q;
  logic [15:0] step_q;
  logic [16:0] leak_q;
  logic [15:0] gain_q;
  logic        en_q;

  // Item and loop registers
  logic [AW-1:0]              clr_q, k_q, last_q;
  logic signed [SAMPLE_W-1:0] mic_q;
  logic                       bend_q;
  logic signed [HIST_W-1:0]   x_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [PW-1:0]              pwr_q;
  logic signed [51:0]         prod_q;
  logic [38:0]                sq_q;
  logic signed [SAMPLE_W-1:0] e_q;
  logic                       clip_q;
  logic [PW-1:0]              den_q;
  logic [30:0]                ex_q;
  logic signed [49:0]         lwp_q;
  logic                       sgn_q;

  // Output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_bend_q;
  logic                       out_clip_q;

  // Memories
  logic signed [WEIGHT_W-1:0] w_mem [MAX_TAPS];
  logic signed [HIST_W-1:0]   h_mem [MAX_TAPS];
  logic signed [WEIGHT_W-1:0] w_rd_q;
  logic signed [HIST_W-1:0]   h_rd_q;
  logic                       w_we, h_we;
  logic [AW-1:0]              w_wa, h_wa, h_ra;
  logic signed [WEIGHT_W-1:0] w_wd;
  logic signed [HIST_W-1:0]   h_wd;

  // Datapath nets
  logic                       in_acc;
  logic                       cfg_acc;
  logic [31:0]                taps_ext;
  logic [AW-1:0]              last_c;
  logic signed [32:0]         x_prod;
  logic signed [33:0]         x_rnd;
  logic signed [21:0]         x_sh;
  logic signed [HIST_W-1:0]   x_c;
  logic signed [HIST_W-1:0]   hv;
  logic signed [51:0]         prod_c;
  logic signed [39:0]         sq_c;
  logic signed [ACC_W:0]      est_rnd;
  logic signed [ACC_W-28:0]   est_c;
  logic signed [ERR_W-1:0]    err_c;
  logic                       clip_c;
  logic signed [SAMPLE_W-1:0] e_c;
  logic [15:0]                e_abs;
  logic [19:0]                h_abs;
  logic [50:0]                mag_c;
  logic [NUM_W-1:0]           num_c;
  logic                       div_start;
  logic                       div_done;
  logic [NUM_W-1:0]           quot;
  logic signed [50:0]         lw_rnd;
  logic signed [34:0]         lw_c;
  logic signed [63:0]         t_c;
  logic signed [65:0]         wsum_c;
  logic signed [WEIGHT_W-1:0] wnew_c;

  assign in_acc  = in_i.valid && in_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= TAP_COUNT_RST;
      step_q <= STEP_SIZE_RST;
      leak_q <= LEAK_RST;
      gain_q <= REF_GAIN_RST;
      en_q   <= CANCEL_EN_RST;
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        REG_TAP_COUNT: tap_q  <= cfg_i.data[10:0];
        REG_STEP_SIZE: step_q <= cfg_i.data[15:0];
        REG_LEAK:      leak_q <= cfg_i.data[16:0];
        REG_REF_GAIN:  gain_q <= cfg_i.data[15:0];
        REG_CANCEL_EN: en_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Clamp the tap count and form the last tap index
  always_comb begin
    taps_ext = {21'b0, tap_q};
    if (taps_ext < MIN_TAPS) begin
      last_c = AW'(MIN_TAPS - 1);
    end else if (taps_ext > MAX_TAPS) begin
      last_c = AW'(MAX_TAPS - 1);
    end else begin
      last_c = AW'(taps_ext - 32'd1);
    end
  end

  // Scale the reference by the gain, round and saturate to the history width
  always_comb begin
    x_prod = in_i.ref_sample * signed'({1'b0, gain_q});
    x_rnd  = 34'(x_prod) + 34'sd2048;
    x_sh   = x_rnd[33:12];
    if (x_sh[21:19] == 3'b000 || x_sh[21:19] == 3'b111) begin
      x_c = x_sh[19:0];
    end else begin
      x_c = x_sh[21] ? signed'(20'h80000) : signed'(20'h7ffff);
    end
  end

  // Filter pass: new history tap, products for estimate and power
  always_comb begin
    hv     = (k_q == '0) ? x_q : h_rd_q;
    prod_c = w_rd_q * hv;
    sq_c   = hv * hv;
  end

  // Estimate, error and saturation
  always_comb begin
    est_rnd = (ACC_W + 1)'(acc_q) + EST_HALF;
    est_c   = est_rnd[ACC_W:28];
    err_c   = ERR_W'(mic_q) - ERR_W'(est_c);
    clip_c  = !(&err_c[ERR_W-1:15] || !(|err_c[ERR_W-1:15]));
    if (clip_c) begin
      e_c = err_c[ERR_W-1] ? signed'(16'h8000) : signed'(16'h7fff);
    end else begin
      e_c = err_c[15:0];
    end
    e_abs = e_q[15] ? 16'(-e_q) : 16'(e_q);
  end

  // Update numerator for one tap: (ex * |h|) << 12 plus half the divisor
  always_comb begin
    h_abs = h_rd_q[19] ? 20'(-h_rd_q) : 20'(h_rd_q);
    mag_c = 51'(ex_q) * 51'(h_abs);
    num_c = {mag_c, 12'b0} + NUM_W'(den_q >> 1);
  end

  // Leaked weight plus signed gradient step, saturated to 32 bits
  always_comb begin
    lw_rnd = 51'(lwp_q) + 51'sd32768;
    lw_c   = lw_rnd[50:16];
    t_c    = sgn_q ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
    wsum_c = 66'(lw_c) + 66'(t_c);
    if (&wsum_c[65:31] || !(|wsum_c[65:31])) begin
      wnew_c = wsum_c[31:0];
    end else begin
      wnew_c = wsum_c[65] ? signed'(32'h8000_0000) : signed'(32'h7fff_ffff);
    end
  end

  assign div_start = (state_q == S_UMUL);

  nec_div #(
    .NUM_W (NUM_W),
    .DEN_W (PW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_c),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Memory port steering
  always_comb begin
    h_we = (state_q == S_CLR) || (state_q == S_MAC);
    h_wa = (state_q == S_CLR) ? clr_q : k_q;
    h_wd = (state_q == S_CLR) ? '0 : hv;
    h_ra = (state_q == S_MRD) ? AW'(k_q - 1'b1) : k_q;
    w_we = (state_q == S_CLR) || (state_q == S_WUP);
    w_wa = (state_q == S_CLR) ? clr_q : k_q;
    w_wd = (state_q == S_CLR) ? '0 : wnew_c;
  end

  // Weight and history memories, registered reads
  always_ff @(posedge clk_i) begin
    if (w_we) begin
      w_mem[w_wa] <= w_wd;
    end
    w_rd_q <= w_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_mem[h_wa] <= h_wd;
    end
    h_rd_q <= h_mem[h_ra];
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_q == AW'(MAX_TAPS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == OP_CLEAR) begin
            state_d = S_CLR;
          end else if (!en_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_MRD;
          end
        end
      end
      S_MRD:  state_d = S_MAC;
      S_MAC:  state_d = S_MACC;
      S_MACC: state_d = (k_q == '0) ? S_EST : S_MRD;
      S_EST:  state_d = S_EX;
      S_EX:   state_d = S_URD;
      S_URD:  state_d = S_UMUL;
      S_UMUL: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_WUP;
      S_WUP:  state_d = (k_q == last_q) ? S_DONE : S_URD;
      S_DONE: if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_CLR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= AW'(clr_q + 1'b1);
      end else begin
        clr_q <= '0;
      end
      // Walk taps down for the filter pass, up for the update
      if (state_q == S_IDLE && in_acc) begin
        k_q <= last_c;
      end else if (state_q == S_MACC && k_q != '0) begin
        k_q <= k_q - 1'b1;
      end else if (state_q == S_EX) begin
        k_q <= '0;
      end else if (state_q == S_WUP && k_q != last_q) begin
        k_q <= k_q + 1'b1;
      end
      if (state_q == S_DONE && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        mic_q  <= in_i.mic_sample;
        bend_q <= in_i.block_end;
        x_q    <= x_c;
        last_q <= last_c;
        acc_q  <= '0;
        pwr_q  <= '0;
        e_q    <= in_i.mic_sample;
        clip_q <= 1'b0;
      end
      S_MAC: begin
        prod_q <= prod_c;
        sq_q   <= sq_c[38:0];
      end
      S_MACC: begin
        acc_q <= acc_q + ACC_W'(prod_q);
        pwr_q <= pwr_q + PW'(sq_q);
      end
      S_EST: begin
        e_q    <= e_c;
        clip_q <= clip_c;
        den_q  <= pwr_q + 1'b1;
      end
      S_EX:   ex_q <= 31'(32'(e_abs) * 32'(step_q));
      S_UMUL: begin
        lwp_q <= signed'({1'b0, leak_q}) * w_rd_q;
        sgn_q <= e_q[15] ^ h_rd_q[19];
      end
      default: ;
    endcase
    if (state_q == S_DONE && state_d == S_IDLE) begin
      out_sample_q <= e_q;
      out_bend_q   <= bend_q;
      out_clip_q   <= clip_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.clean_sample  = out_sample_q;
  assign out_o.block_end_out = out_bend_q;
  assign out_o.clipped       = out_clip_q;

  // A clear transaction starts the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.opcode == OP_CLEAR) |=> state_q == S_CLR)
    else $error("clear did not start clearing pass");

  // Divider finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider done outside wait state");

  // Update walk never passes the last tap in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_URD || state_q == S_WUP) |-> k_q <= last_q)
    else $error("tap index beyond taps in use");

  // A new result is loaded only out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result loaded outside done state");

endmodule

// ===== hw/rtl/nec_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module nec_div #(
  parameter int unsigned NUM_W = 63,
  parameter int unsigned DEN_W = 49
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(NUM_W);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic             qbit;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    rem_d  = qbit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    num_d  = {num_q[NUM_W-2:0], qbit};
  end

  // Control: count NUM_W iterations, pulse done after the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath: numerator register collects the quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== tb/sv/nlms_echo_canceller_unit_tb.sv =====
// Self-checking testbench for the leaky NLMS echo canceller unit.
`timescale 1ns / 1ps
module nlms_echo_canceller_unit_tb;
  import nec_pkg::*;

  localparam int unsigned DEPTH      = MAX_TAPS_DEF;
  localparam int unsigned STALL_MAX  = 400000;
  localparam int unsigned SETTLE_CYC = 1500;
  localparam int unsigned HOLD_CYC   = 300;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] clean;
    logic                       bend;
    logic                       clip;
  } clean_out_t;

  // Echo canceller model with its own filter state and a queue of pending outputs
  class echo_scoreboard;
    int         weights [DEPTH];
    int         history [DEPTH];
    int unsigned taps, mu, leak, gain;
    bit          enable;
    clean_out_t  pending_q[$];
    int unsigned mismatches;

    function void reset_state();
      foreach (weights[k]) begin
        weights[k] = 0;
        history[k] = 0;
      end
      taps = TAP_COUNT_RST; mu = STEP_SIZE_RST; leak = LEAK_RST;
      gain = REF_GAIN_RST; enable = CANCEL_EN_RST;
      pending_q.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TAP_COUNT: taps   = data[10:0];
        REG_STEP_SIZE: mu     = data[15:0];
        REG_LEAK:      leak   = data[16:0];
        REG_REF_GAIN:  gain   = data[15:0];
        REG_CANCEL_EN: enable = data[0];
        default: ;
      endcase
    endfunction

    // Apply one accepted sample pair and queue the result it produces
    function void note_sample(logic op, logic signed [15:0] mic, logic signed [15:0] refs,
                              logic bend);
      int unsigned n;
      longint x, acc, est, err, e, h, t, lw, w;
      longint unsigned pwr, den, ex, mag, q;
      clean_out_t r;
      if (op == OP_CLEAR) begin
        foreach (weights[k]) begin
          weights[k] = 0;
          history[k] = 0;
        end
        return;
      end
      if (!enable) begin
        r.clean = mic; r.bend = bend; r.clip = 1'b0;
        pending_q.push_back(r);
        return;
      end
      n = (taps < MIN_TAPS) ? MIN_TAPS : ((taps > DEPTH) ? DEPTH : taps);
      for (int k = n - 1; k > 0; k--) history[k] = history[k-1];
      x = (longint'(refs) * longint'(gain) + 2048) >>> 12;
      if (x > 524287) x = 524287;
      if (x < -524288) x = -524288;
      history[0] = int'(x);
      acc = 0;
      pwr = 0;
      for (int k = 0; k < n; k++) begin
        h = history[k];
        acc += longint'(weights[k]) * h;
        pwr += longint'(h * h);
      end
      est = (acc + (longint'(1) <<< 27)) >>> 28;
      err = longint'(mic) - est;
      e = err;
      r.clip = 1'b0;
      if (e > 32767) begin e = 32767; r.clip = 1'b1; end
      if (e < -32768) begin e = -32768; r.clip = 1'b1; end
      den = pwr + 1;
      ex = longint'(mu) * ((e < 0) ? -e : e);
      // Leak each weight and step it along the normalized gradient
      for (int k = 0; k < n; k++) begin
        h = history[k];
        mag = (ex * longint'((h < 0) ? -h : h)) << 12;
        q = (mag + den / 2) / den;
        t = ((e < 0) != (h < 0)) ? -longint'(q) : longint'(q);
        lw = (longint'(leak) * longint'(weights[k]) + 32768) >>> 16;
        w = lw + t;
        if (w > 64'sd2147483647) w = 64'sd2147483647;
        if (w < -64'sd2147483648) w = -64'sd2147483648;
        weights[k] = int'(w);
      end
      r.clean = e[15:0];
      r.bend = bend;
      pending_q.push_back(r);
    endfunction

    function void check_output(clean_out_t got);
      clean_out_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected output: clean=%0d bend=%0b clip=%0b",
                   got.clean, got.bend, got.clip);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("mismatch: expected clean=%0d bend=%0b clip=%0b,",
                   want.clean, want.bend, want.clip,
                   " got clean=%0d bend=%0b clip=%0b",
                   got.clean, got.bend, got.clip);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nec_cfg_if cfg_if ();
  nec_in_if  in_if ();
  nec_out_if out_if ();

  nlms_echo_canceller_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  echo_scoreboard sb;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned rx_mode, rx_len, rx_phase;

  // Free-running clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Track accepted transactions on every channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready)
        sb.note_sample(in_if.opcode, in_if.mic_sample, in_if.ref_sample, in_if.block_end);
      if (out_if.valid && out_if.ready)
        sb.check_output('{out_if.clean_sample, out_if.block_end_out, out_if.clipped});
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((cfg_if.valid && cfg_if.ready) || (in_if.valid && in_if.ready) ||
        (out_if.valid && out_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_MAX) begin
      $display("** nlms_echo_canceller_unit: FAILED **");
      $finish;
    end
  end

  // Receiver: stall on a changing pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYC;
      out_if.ready <= 1'b0;
    end else begin
      rx_phase++;
      if (rx_phase >= rx_len) begin
        rx_phase = 0;
        rx_mode = $urandom_range(0, 3);
        rx_len = $urandom_range(20, 400);
      end
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        2: out_if.ready <= ((rx_phase % 4) != 3);
        default: out_if.ready <= ((rx_phase % 16) < 3);
      endcase
    end
  end

  task automatic wait_cycles(int unsigned n);
    repeat (n) @(posedge clk_i);
  endtask

  // Write one register, then leave the channel idle
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain outstanding results and let a clearing pass finish before reconfiguring
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    wait_cycles(SETTLE_CYC);
  endtask

  task automatic configure(int unsigned taps, int unsigned mu, int unsigned leak,
                           int unsigned gain, bit en);
    drain();
    write_cfg(REG_TAP_COUNT, CFG_DATA_W'(taps));
    write_cfg(REG_STEP_SIZE, CFG_DATA_W'(mu));
    write_cfg(REG_LEAK, CFG_DATA_W'(leak));
    write_cfg(REG_REF_GAIN, CFG_DATA_W'(gain));
    write_cfg(REG_CANCEL_EN, CFG_DATA_W'(en));
  endtask

  // Offer one item, with burst gaps between groups of items
  task automatic send_sample(logic op, logic [15:0] mic, logic [15:0] refs, logic bend);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        wait_cycles($urandom_range(1, 30));
      end
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.mic_sample <= mic;
    in_if.ref_sample <= refs;
    in_if.block_end  <= bend;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic pick_sample(output logic [15:0] v);
    case ($urandom_range(0, 9))
      0: v = 16'h7fff;
      1: v = 16'h8000;
      2: v = 16'($urandom_range(0, 255)) - 16'd128;
      default: v = 16'($urandom);
    endcase
  endtask

  task automatic random_samples(int unsigned count);
    logic [15:0] mic, refs;
    for (int i = 0; i < count; i++) begin
      pick_sample(mic);
      pick_sample(refs);
      send_sample(($urandom_range(0, 29) == 0) ? OP_CLEAR : OP_PROCESS, mic, refs,
                  1'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    clk_i = 1'b0;
    idle_cycles = 0; burst_left = 0; hold_req = 1'b0; hold_left = 0;
    rx_mode = 0; rx_len = 50; rx_phase = 0;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    in_if.valid = 1'b0; in_if.opcode = OP_PROCESS;
    in_if.mic_sample = '0; in_if.ref_sample = '0; in_if.block_end = 1'b0;
    out_if.ready = 1'b0;
    wait_cycles(4);
    rst_ni <= 1'b1;
    wait_cycles(SETTLE_CYC);

    // Reset defaults
    send_sample(OP_PROCESS, 16'd1000, 16'd2000, 1'b0);
    send_sample(OP_PROCESS, 16'h8000, 16'h7fff, 1'b1);
    send_sample(OP_PROCESS, 16'h7fff, 16'h8000, 1'b0);

    // Extremes: full step, unity leak, maximum gain
    configure(8, 65535, 65536, 65535, 1'b1);
    write_cfg(REG_UNUSED, 17'h1ffff);
    send_sample(OP_PROCESS, 16'h7fff, 16'h7fff, 1'b1);
    send_sample(OP_PROCESS, 16'h8000, 16'h8000, 1'b0);
    send_sample(OP_PROCESS, 16'h7fff, 16'h8000, 1'b1);
    send_sample(OP_PROCESS, 16'h8000, 16'h7fff, 1'b0);
    send_sample(OP_PROCESS, 16'h0000, 16'h0000, 1'b1);
    send_sample(OP_PROCESS, 16'h7fff, 16'h7fff, 1'b0);
    send_sample(OP_CLEAR, 16'h1234, 16'h4321, 1'b1);
    send_sample(OP_PROCESS, 16'h0001, 16'hffff, 1'b1);
    send_sample(OP_PROCESS, 16'h8000, 16'h7fff, 1'b0);

    // Leak above one grows weights toward saturation
    configure(8, 65535, 131071, 65535, 1'b1);
    random_samples(12);

    // Tap count above the store size acts as the full depth
    configure(2047, 328, 65470, 4096, 1'b1);
    send_sample(OP_PROCESS, 16'd5000, 16'h7fff, 1'b1);
    send_sample(OP_PROCESS, 16'h8000, 16'd3000, 1'b0);

    // Tap count below the minimum, zero step, zero leak, zero gain
    configure(0, 0, 0, 0, 1'b1);
    random_samples(20);

    // Bypass, with a long output hold-off so the input backs up
    configure(3, 1000, 65000, 8192, 1'b0);
    hold_req = 1'b1;
    random_samples(40);

    // Random settings, mostly small filters
    for (int p = 0; p < 8; p++) begin
      configure($urandom_range(5, 24), $urandom_range(0, 65535),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                            : $urandom_range(60000, 65536),
                $urandom_range(0, 65535), ($urandom_range(0, 5) != 0));
      random_samples(55);
    end

    drain();
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("** nlms_echo_canceller_unit: PASSED **");
    else
      $display("** nlms_echo_canceller_unit: FAILED **");
    $finish;
  end

endmodule

// ===== nlms_echo_canceller_unit.f =====
hw/rtl/nec_pkg.sv
hw/rtl/nec_if.sv
hw/rtl/nec_div.sv
hw/rtl/nlms_echo_canceller_unit.sv
tb/sv/nlms_echo_canceller_unit_tb.sv
